// ----- rtl/core/gnb_pkg.sv -----
package gnb_pkg;

    // model dimensions
    localparam int MAX_CLASSES = 8;
    localparam int MAX_ATTRS   = 16;

    localparam int CLS_W      = $clog2(MAX_CLASSES);
    localparam int ATTR_W     = $clog2(MAX_ATTRS);
    localparam int ENTRY_AW   = CLS_W + ATTR_W;
    localparam int ENTRY_DEPTH = MAX_CLASSES * MAX_ATTRS;

    // field and register widths
    localparam int VAL_W   = 32;
    localparam int SCORE_W = 48;
    localparam int PEN_W   = SCORE_W - 1;
    localparam int NC_W    = 4;
    localparam int NA_W    = 5;
    localparam int OP_W    = 2;

    // stream packing
    localparam int IN_FIELDS_W  = CLS_W + ATTR_W + 4 * VAL_W;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = CLS_W + SCORE_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    // config port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    typedef enum logic [0:0] {
        REG_NUM_CLASSES = 1'b0,
        REG_NUM_ATTRS   = 1'b1
    } t_reg;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD_ENTRY = 2'd0,
        OP_LOAD_BIAS  = 2'd1,
        OP_FEATURE    = 2'd2,
        OP_NONE       = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic              wr_entry;
        logic              wr_bias;
        logic              capture;
        logic              issue;
        logic [CLS_W-1:0]  cls;
        logic [ATTR_W-1:0] attr;
        logic              first;
        logic              emit;
    } t_dp_cmd;

    typedef struct packed {
        logic pipe_busy;
        logic out_free;
    } t_dp_sts;

endpackage

// ----- rtl/core/gnb_ram.sv -----
module gnb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/gnb_datapath.sv -----
module gnb_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  gnb_pkg::t_dp_cmd             i_cmd,
    output gnb_pkg::t_dp_sts             o_sts,
    input  logic [gnb_pkg::CLS_W-1:0]    i_class_index,
    input  logic [gnb_pkg::ATTR_W-1:0]   i_attr_index,
    input  logic [gnb_pkg::VAL_W-1:0]    i_mean_value,
    input  logic [gnb_pkg::VAL_W-1:0]    i_weight_value,
    input  logic [gnb_pkg::VAL_W-1:0]    i_bias_value,
    input  logic [gnb_pkg::VAL_W-1:0]    i_feature_value,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic [gnb_pkg::CLS_W-1:0]    o_predicted_class,
    output logic [gnb_pkg::SCORE_W-1:0]  o_best_score
);
    import gnb_pkg::*;

    localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};
    localparam logic [PEN_W-1:0]          PEN_MAX   = {PEN_W{1'b1}};

    // model storage: mean in the low half, weight in the high half
    logic [2*VAL_W-1:0] w_entry_rd;
    logic [VAL_W-1:0]   w_bias_rd;

    gnb_ram #(.WIDTH(2 * VAL_W), .DEPTH(ENTRY_DEPTH)) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_entry),
        .i_waddr ({i_class_index, i_attr_index}),
        .i_wdata ({i_weight_value, i_mean_value}),
        .i_raddr ({i_cmd.cls, i_cmd.attr}),
        .o_rdata (w_entry_rd)
    );

    gnb_ram #(.WIDTH(VAL_W), .DEPTH(MAX_CLASSES)) u_bias_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_bias),
        .i_waddr (i_class_index),
        .i_wdata (i_bias_value),
        .i_raddr (i_cmd.cls),
        .o_rdata (w_bias_rd)
    );

    // sample value
    logic signed [VAL_W-1:0] r_x;

    // stage valids
    logic r_v0, r_va, r_vb, r_vc, r_vd, r_ve;

    // stage payload
    logic [CLS_W-1:0]         r_cls0, r_clsa, r_clsb, r_clsc, r_clsd, r_clse;
    logic [VAL_W-1:0]         r_mag, r_wa, r_wb;
    logic [VAL_W-1:0]         r_biasa, r_biasb, r_biasc, r_biasd;
    logic [2*VAL_W-1:0]       r_sq, r_phi;
    logic [VAL_W-1:0]         r_plo;
    logic [PEN_W-1:0]         r_pen;
    logic signed [SCORE_W-1:0] r_acc;
    logic signed [SCORE_W-1:0] r_score [MAX_CLASSES];
    logic signed [SCORE_W-1:0] r_best;
    logic [CLS_W-1:0]         r_best_cls;

    // output slot
    logic                     r_out_valid;
    logic [CLS_W-1:0]         r_out_cls;
    logic [SCORE_W-1:0]       r_out_score;

    // stage A: |x - mu|
    logic signed [VAL_W:0]    w_diff, w_neg;
    logic [VAL_W-1:0]         w_mag;

    // stage C/D: weight products and penalty
    logic [2*VAL_W-1:0]       w_plo, w_t;
    logic [PEN_W-1:0]         w_pen;

    // stage E: score update
    logic signed [SCORE_W-1:0] w_base, w_acc;
    logic signed [SCORE_W:0]   w_acc_wide;

    always_comb begin
        w_diff = {r_x[VAL_W-1], r_x} - {w_entry_rd[VAL_W-1], w_entry_rd[VAL_W-1:0]};
        w_neg  = -w_diff;
        w_mag  = w_diff[VAL_W] ? w_neg[VAL_W-1:0] : w_diff[VAL_W-1:0];
    end

    assign w_plo = r_sq[VAL_W-1:0] * r_wb;
    assign w_t   = r_phi + {{VAL_W{1'b0}}, r_plo};
    assign w_pen = (|w_t[2*VAL_W-1:PEN_W]) ? PEN_MAX : w_t[PEN_W-1:0];

    always_comb begin
        w_base = i_cmd.first ? SCORE_W'(signed'(r_biasd)) : r_score[r_clsd];
        w_acc_wide = {w_base[SCORE_W-1], w_base} - {2'b00, r_pen};
        if (w_acc_wide[SCORE_W] && !w_acc_wide[SCORE_W-1]) begin
            w_acc = SCORE_MIN;
        end else begin
            w_acc = w_acc_wide[SCORE_W-1:0];
        end
    end

    // control: stage valids, scores, output slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
            r_ve <= 1'b0;
            r_out_valid <= 1'b0;
            for (int c = 0; c < MAX_CLASSES; c++) begin
                r_score[c] <= '0;
            end
        end else begin
            r_v0 <= i_cmd.issue;
            r_va <= r_v0;
            r_vb <= r_va;
            r_vc <= r_vb;
            r_vd <= r_vc;
            r_ve <= r_vd;
            if (r_vd) begin
                r_score[r_clsd] <= w_acc;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_x <= i_feature_value;
        end
        r_cls0  <= i_cmd.cls;
        // A
        r_mag   <= w_mag;
        r_wa    <= w_entry_rd[2*VAL_W-1:VAL_W];
        r_biasa <= w_bias_rd;
        r_clsa  <= r_cls0;
        // B
        r_sq    <= r_mag * r_mag;
        r_wb    <= r_wa;
        r_biasb <= r_biasa;
        r_clsb  <= r_clsa;
        // C
        r_phi   <= r_sq[2*VAL_W-1:VAL_W] * r_wb;
        r_plo   <= w_plo[2*VAL_W-1:VAL_W];
        r_biasc <= r_biasb;
        r_clsc  <= r_clsb;
        // D
        r_pen   <= w_pen;
        r_biasd <= r_biasc;
        r_clsd  <= r_clsc;
        // E
        r_acc   <= w_acc;
        r_clse  <= r_clsd;
        // F: running argmax, class 0 opens the sweep, ties keep the lower class
        if (r_ve && (r_clse == '0 || r_acc > r_best)) begin
            r_best     <= r_acc;
            r_best_cls <= r_clse;
        end
        if (i_cmd.emit) begin
            r_out_cls   <= r_best_cls;
            r_out_score <= r_best;
        end
    end

    assign o_sts.pipe_busy = r_v0 | r_va | r_vb | r_vc | r_vd | r_ve;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid       = r_out_valid;
    assign o_predicted_class = r_out_cls;
    assign o_best_score      = r_out_score;

endmodule

// ----- rtl/core/gnb_ctrl.sv -----
module gnb_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  gnb_pkg::t_op              i_op,
    input  logic [gnb_pkg::NC_W-1:0]  i_num_classes,
    input  logic [gnb_pkg::NA_W-1:0]  i_num_attrs,
    input  gnb_pkg::t_dp_sts          i_sts,
    output logic                      o_in_ready,
    output gnb_pkg::t_dp_cmd          o_cmd
);
    import gnb_pkg::*;

    t_state              r_state, n_state;
    logic [CLS_W-1:0]    r_cls;
    logic [ATTR_W-1:0]   r_attr;
    logic [ATTR_W-1:0]   r_item_attr;
    logic                r_first;
    logic                r_last;

    logic                w_accept;
    logic                w_feature;
    logic                w_cls_end;
    logic                w_last_attr;

    assign w_accept    = i_in_valid && (r_state == S_IDLE);
    assign w_feature   = w_accept && (i_op == OP_FEATURE);
    assign w_cls_end   = ({1'b0, r_cls} == (i_num_classes - NC_W'(1)));
    assign w_last_attr = (({1'b0, r_attr} + NA_W'(1)) >= i_num_attrs);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_feature) n_state = S_RUN;
            end
            S_RUN: begin
                if (w_cls_end) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                if (!i_sts.pipe_busy) n_state = r_last ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready     = 1'b0;
        o_cmd.wr_entry = 1'b0;
        o_cmd.wr_bias  = 1'b0;
        o_cmd.capture  = 1'b0;
        o_cmd.issue    = 1'b0;
        o_cmd.emit     = 1'b0;
        o_cmd.cls      = r_cls;
        o_cmd.attr     = r_item_attr;
        o_cmd.first    = r_first;
        case (r_state)
            S_IDLE: begin
                o_in_ready     = 1'b1;
                o_cmd.wr_entry = w_accept && (i_op == OP_LOAD_ENTRY);
                o_cmd.wr_bias  = w_accept && (i_op == OP_LOAD_BIAS);
                o_cmd.capture  = w_feature;
            end
            S_RUN: begin
                o_cmd.issue = 1'b1;
            end
            S_EMIT: begin
                o_cmd.emit = i_sts.out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cls       <= '0;
            r_attr      <= '0;
            r_item_attr <= '0;
            r_first     <= 1'b0;
            r_last      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_feature) begin
                r_item_attr <= r_attr;
                r_first     <= (r_attr == '0);
                r_last      <= w_last_attr;
                r_attr      <= w_last_attr ? '0 : r_attr + ATTR_W'(1);
                r_cls       <= '0;
            end else if (r_state == S_RUN) begin
                r_cls <= r_cls + CLS_W'(1);
            end
        end
    end

endmodule

// ----- rtl/core/gaussian_naive_bayes_classifier_unit.sv -----
// Gaussian naive Bayes classifier, log domain, signed Q16.16 in, Q32.16 score out.
// Requests on the slave stream carry an opcode in tuser: load a class/attribute
// mean and weight 1/(2*sigma^2), load a class bias (log prior minus sum of log
// sigma), or present the next attribute of a sample. Each attribute subtracts
// the saturated (x-mu)^2*w from each used class score; the first attribute of a
// sample seeds the scores from the biases. The last attribute sends one result
// request: the highest-scoring class (lowest index on ties) and its score.
// A load leaves the slave side ready; a feature request holds the slave
// side through the class sweep and the drain, on the last attribute also until
// the result is in the output register. The sweep runs on the single shared
// square-and-weight pipeline, which takes one class per cycle. The result waits
// in an output register, so the slave side keeps taking requests while the
// master side stalls, until the next sample ends; that sample then holds the
// slave side until the output register frees up. Class/attribute counts are
// written over the APB port (0x0 num_classes, 0x4 num_attributes); the user
// must write them only while idle, the block does not enforce it. Out-of-range
// counts are clamped. Model memories are not cleared at reset.
module gaussian_naive_bayes_classifier_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // slave stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [2:0] class_index, [6:3] attr_index, [38:7] mean_value,
    // [70:39] weight_value, [102:71] bias_value, [134:103] feature_value
    input  logic [gnb_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // [1:0] op
    input  logic [gnb_pkg::OP_W-1:0]        s_axis_tuser,
    // master stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [2:0] predicted_class, [50:3] best_score
    output logic [gnb_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // config port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [gnb_pkg::APB_AW-1:0]      paddr,
    input  logic [gnb_pkg::APB_DW-1:0]      pwdata,
    output logic [gnb_pkg::APB_DW-1:0]      prdata,
    output logic                            pready
);
    import gnb_pkg::*;

    // field offsets in s_axis_tdata
    localparam int ATTR_LSB = CLS_W;
    localparam int MEAN_LSB = ATTR_LSB + ATTR_W;
    localparam int WGT_LSB  = MEAN_LSB + VAL_W;
    localparam int BIAS_LSB = WGT_LSB + VAL_W;
    localparam int FEAT_LSB = BIAS_LSB + VAL_W;

    localparam logic [NC_W-1:0] NC_MIN = NC_W'(2);
    localparam logic [NC_W-1:0] NC_MAX = NC_W'(MAX_CLASSES);
    localparam logic [NA_W-1:0] NA_MIN = NA_W'(1);
    localparam logic [NA_W-1:0] NA_MAX = NA_W'(MAX_ATTRS);

    // config registers
    logic [NC_W-1:0] r_num_classes;
    logic [NA_W-1:0] r_num_attrs;
    logic [NC_W-1:0] w_nc_used;
    logic [NA_W-1:0] w_na_used;
    logic            w_cfg_wr;
    t_reg            w_reg_sel;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_reg_sel = t_reg'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_classes <= NC_W'(2);
            r_num_attrs   <= NA_W'(1);
        end else if (w_cfg_wr) begin
            case (w_reg_sel)
                REG_NUM_CLASSES: r_num_classes <= pwdata[NC_W-1:0];
                REG_NUM_ATTRS:   r_num_attrs   <= pwdata[NA_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg_sel)
            REG_NUM_CLASSES: prdata = APB_DW'(r_num_classes);
            REG_NUM_ATTRS:   prdata = APB_DW'(r_num_attrs);
            default:         prdata = '0;
        endcase
    end

    // clamp counts to what the tables hold
    always_comb begin
        if (r_num_classes < NC_MIN) begin
            w_nc_used = NC_MIN;
        end else if (r_num_classes > NC_MAX) begin
            w_nc_used = NC_MAX;
        end else begin
            w_nc_used = r_num_classes;
        end
        if (r_num_attrs < NA_MIN) begin
            w_na_used = NA_MIN;
        end else if (r_num_attrs > NA_MAX) begin
            w_na_used = NA_MAX;
        end else begin
            w_na_used = r_num_attrs;
        end
    end

    t_dp_cmd             w_cmd;
    t_dp_sts             w_sts;
    logic [CLS_W-1:0]    w_pred;
    logic [SCORE_W-1:0]  w_score;

    gnb_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (s_axis_tvalid),
        .i_op          (t_op'(s_axis_tuser)),
        .i_num_classes (w_nc_used),
        .i_num_attrs   (w_na_used),
        .i_sts         (w_sts),
        .o_in_ready    (s_axis_tready),
        .o_cmd         (w_cmd)
    );

    gnb_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_class_index     (s_axis_tdata[CLS_W-1:0]),
        .i_attr_index      (s_axis_tdata[ATTR_LSB +: ATTR_W]),
        .i_mean_value      (s_axis_tdata[MEAN_LSB +: VAL_W]),
        .i_weight_value    (s_axis_tdata[WGT_LSB +: VAL_W]),
        .i_bias_value      (s_axis_tdata[BIAS_LSB +: VAL_W]),
        .i_feature_value   (s_axis_tdata[FEAT_LSB +: VAL_W]),
        .i_out_ready       (m_axis_tready),
        .o_out_valid       (m_axis_tvalid),
        .o_predicted_class (w_pred),
        .o_best_score      (w_score)
    );

    assign m_axis_tdata = {{(OUT_DATA_W - OUT_FIELDS_W){1'b0}}, w_score, w_pred};

endmodule

// ----- rtl/core/gnb_checker.sv -----
module gnb_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic [gnb_pkg::OP_W-1:0]       s_axis_tuser,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [gnb_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import gnb_pkg::*;

    // a feature request always starts the class sweep, so the slave side closes
    a_feature_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_FEATURE
        |=> !s_axis_tready)
        else $error("slave ready after feature request");

    // loads and no-ops leave the slave side ready
    a_load_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser != OP_FEATURE
        |=> s_axis_tready)
        else $error("slave stalled after load request");

    // a result only appears out of a busy period
    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared while idle");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind gaussian_naive_bayes_classifier_unit gnb_checker u_gnb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ----- tb/sv/gaussian_naive_bayes_classifier_unit_tb.sv -----
module gaussian_naive_bayes_classifier_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gnb_pkg::*;

    // run pacing
    localparam int STUCK_LIMIT = 3000;  // cycles with no handshake anywhere
    localparam int QUIET       = 32;    // lets a silent feature finish
    localparam int TAIL_CYCLES = 40;
    localparam int HOLD_OFF    = 500;   // long master-side stall, fills the block
    localparam int PHASE_ITEMS = 80;

    localparam longint SCORE_LO = -(longint'(1) <<< (SCORE_W - 1));

    // one slave-side request, unused fields carry noise
    typedef struct {
        t_op               op;
        logic [CLS_W-1:0]  cls;
        logic [ATTR_W-1:0] attr;
        logic [VAL_W-1:0]  mean;
        logic [VAL_W-1:0]  weight;
        logic [VAL_W-1:0]  bias;
        logic [VAL_W-1:0]  feat;
    } t_req;

    // one master-side request
    typedef struct {
        logic [CLS_W-1:0]   cls;
        logic [SCORE_W-1:0] score;
    } t_verdict;

    typedef struct {
        t_req               rq;
        bit                 typed;
        logic [CLS_W-1:0]   cls;
        logic [SCORE_W-1:0] score;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [OP_W-1:0]       s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    // predictor state: model tables, running class scores, sample position
    logic [VAL_W-1:0] mean_mem   [ENTRY_DEPTH];
    logic [VAL_W-1:0] weight_mem [ENTRY_DEPTH];
    logic [VAL_W-1:0] bias_mem   [MAX_CLASSES];
    longint           class_score[MAX_CLASSES] = '{default: 0};
    int               attr_pos    = 0;
    logic [NC_W-1:0]  cfg_classes = NC_W'(2);
    logic [NA_W-1:0]  cfg_attrs   = NA_W'(1);

    t_verdict verdicts_due[$];
    t_dir_row dir_rows[$];
    int       results_seen   = 0;
    int       mismatch_count = 0;
    int       items_sent     = 0;
    int       burst_left     = 0;
    int       stuck_cycles   = 0;

    always #5 i_clk = ~i_clk;

    gaussian_naive_bayes_classifier_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // out-of-range counts are clamped, the registers keep the raw value
    function automatic int used_class_count();
        if (cfg_classes < 2) return 2;
        if (cfg_classes > MAX_CLASSES) return MAX_CLASSES;
        return int'(cfg_classes);
    endfunction

    function automatic int used_attr_count();
        if (cfg_attrs < 1) return 1;
        if (cfg_attrs > MAX_ATTRS) return MAX_ATTRS;
        return int'(cfg_attrs);
    endfunction

    // (x - mu)^2 * w >> 32, held at 2^47 - 1
    function automatic logic [PEN_W-1:0] gauss_penalty(input logic [VAL_W-1:0] x,
                                                       input logic [VAL_W-1:0] mu,
                                                       input logic [VAL_W-1:0] w);
        logic signed [VAL_W:0] d;
        logic [VAL_W-1:0]      mag;
        logic [63:0]           sq;
        logic [95:0]           prod;
        d    = $signed({x[VAL_W-1], x}) - $signed({mu[VAL_W-1], mu});
        // |d| <= 2^32 - 1, fits the unsigned 32 bits
        mag  = d[VAL_W] ? VAL_W'(-d) : d[VAL_W-1:0];
        sq   = 64'(mag) * 64'(mag);
        prod = 96'(sq) * 96'(w);
        if (prod[95:32] > 64'h0000_7FFF_FFFF_FFFF) return '1;
        return prod[32 +: PEN_W];
    endfunction

    // advances the predictor by one accepted request; a result comes back on
    // the last attribute of a sample
    task automatic score_request(input t_req r, output bit has_res, output t_verdict v);
        int     nc;
        int     na;
        int     best;
        longint acc;
        longint best_s;
        has_res = 1'b0;
        v       = '{'0, '0};
        case (r.op)
            OP_LOAD_ENTRY: begin
                mean_mem[int'(r.cls) * MAX_ATTRS + int'(r.attr)]   = r.mean;
                weight_mem[int'(r.cls) * MAX_ATTRS + int'(r.attr)] = r.weight;
            end
            OP_LOAD_BIAS: begin
                bias_mem[r.cls] = r.bias;
            end
            OP_FEATURE: begin
                nc = used_class_count();
                na = used_attr_count();
                // classes beyond nc keep whatever they held
                for (int c = 0; c < nc; c++) begin
                    acc = (attr_pos == 0) ? longint'($signed(bias_mem[c])) : class_score[c];
                    acc -= longint'(gauss_penalty(r.feat, mean_mem[c * MAX_ATTRS + attr_pos],
                                                  weight_mem[c * MAX_ATTRS + attr_pos]));
                    if (acc < SCORE_LO) acc = SCORE_LO;
                    class_score[c] = acc;
                end
                // a lowered attribute count ends the sample right here
                if (attr_pos + 1 < na) begin
                    attr_pos++;
                end else begin
                    attr_pos = 0;
                    best     = 0;
                    best_s   = class_score[0];
                    // strict compare: lowest index wins a tie
                    for (int c = 1; c < nc; c++) begin
                        if (class_score[c] > best_s) begin
                            best_s = class_score[c];
                            best   = c;
                        end
                    end
                    has_res = 1'b1;
                    v.cls   = CLS_W'(best);
                    v.score = best_s[SCORE_W-1:0];
                end
            end
            default: ;  // unused opcode, no effect
        endcase
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic t_req mk_req(input t_op op, input logic [CLS_W-1:0] cls,
                                    input logic [ATTR_W-1:0] attr,
                                    input logic [VAL_W-1:0] mean,
                                    input logic [VAL_W-1:0] weight,
                                    input logic [VAL_W-1:0] bias,
                                    input logic [VAL_W-1:0] feat);
        t_req r;
        r.op     = op;
        r.cls    = cls;
        r.attr   = attr;
        r.mean   = mean;
        r.weight = weight;
        r.bias   = bias;
        r.feat   = feat;
        return r;
    endfunction

    // mostly values in +/-half so scores stay apart, now and then the full range
    function automatic logic [VAL_W-1:0] rand_spread(input int unsigned half);
        if ($urandom_range(0, 4) == 0) return $urandom;
        return VAL_W'($urandom_range(0, 2 * half)) - VAL_W'(half);
    endfunction

    // feature near one class mean for the current attribute, sometimes anywhere
    function automatic logic [VAL_W-1:0] pick_feature();
        int c;
        if ($urandom_range(0, 9) < 2) return $urandom;
        c = $urandom_range(0, used_class_count() - 1);
        return mean_mem[c * MAX_ATTRS + attr_pos] + rand_spread(32'h0004_0000);
    endfunction

    function automatic t_req rand_entry_load();
        return mk_req(OP_LOAD_ENTRY, CLS_W'($urandom), ATTR_W'($urandom),
                      rand_spread(32'h0010_0000), rand_spread(32'h0001_0000) + 32'h0001_0000,
                      $urandom, $urandom);
    endfunction

    function automatic t_req rand_bias_load();
        return mk_req(OP_LOAD_BIAS, CLS_W'($urandom), ATTR_W'($urandom),
                      $urandom, $urandom, rand_spread(32'h0100_0000), $urandom);
    endfunction

    function automatic t_req rand_feature();
        return mk_req(OP_FEATURE, CLS_W'($urandom), ATTR_W'($urandom),
                      $urandom, $urandom, $urandom, pick_feature());
    endfunction

    function automatic t_req rand_noop();
        return mk_req(OP_NONE, CLS_W'($urandom), ATTR_W'($urandom),
                      $urandom, $urandom, $urandom, $urandom);
    endfunction

    task automatic add_row(input t_req r, input bit typed = 1'b0,
                           input logic [CLS_W-1:0] cls = '0,
                           input logic [SCORE_W-1:0] score = '0);
        t_dir_row row;
        row.rq    = r;
        row.typed = typed;
        row.cls   = cls;
        row.score = score;
        dir_rows.insert(dir_rows.size(), row);
    endtask

    // Slave-side sender: bursts of random length, random gaps between them.
    // Called right after a rising edge; returns at the edge that took the request.
    task automatic send_req(input t_req r, input bit typed = 1'b0,
                            input logic [CLS_W-1:0] want_cls = '0,
                            input logic [SCORE_W-1:0] want_score = '0);
        bit       has_res;
        t_verdict v;
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_DATA_W'({r.feat, r.bias, r.weight, r.mean, r.attr, r.cls});
        s_axis_tuser  <= r.op;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        score_request(r, has_res, v);
        if (has_res) begin
            if (typed) begin
                v.cls   = want_cls;
                v.score = want_score;
            end
            verdicts_due.insert(verdicts_due.size(), v);
        end
        if (r.op != OP_NONE) items_sent++;
    endtask

    // idle the slave side and let every outstanding feature drain
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (verdicts_due.size() != 0) @(posedge i_clk);
        repeat (QUIET) @(posedge i_clk);
    endtask

    // APB write then read back; returns only once psel low has been sampled, so a
    // following call never lowers and raises psel in the same step
    task automatic cfg_write(input t_reg idx, input logic [APB_DW-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(4 * int'(idx));
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (idx == REG_NUM_CLASSES) cfg_classes = val[NC_W-1:0];
        else                        cfg_attrs   = val[NA_W-1:0];
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== val) begin
            $error("%s readback: expected %0h, got %0h", idx.name(), val, prdata);
            mismatch_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // random requests: mostly whole samples, some reloads, no-ops and
    // stray features; a sample left open by a count change is completed
    task automatic run_random(input int quota);
        int goal;
        int pick;
        goal = items_sent + quota;
        while (items_sent < goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 78) begin
                do begin
                    if ($urandom_range(0, 19) == 0) send_req(rand_noop());
                    if ($urandom_range(0, 29) == 0) send_req(rand_entry_load());
                    send_req(rand_feature());
                end while (attr_pos != 0);
            end else if (pick < 88) begin
                send_req(rand_entry_load());
            end else if (pick < 93) begin
                send_req(rand_bias_load());
            end else if (pick < 97) begin
                send_req(rand_noop());
            end else begin
                send_req(rand_feature());
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        // class/attribute counts per phase: clamps below and above, both extremes
        int ph_nc[10] = '{3, 8, 0, 15, 5, 1, 8, 7, 2, 9};
        int ph_na[10] = '{2, 16, 0, 31, 3, 4, 1, 5, 16, 17};

        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_NONE;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at reset counts (2 classes, 1 attribute).
        // Only class 0/1, attribute 0 and both biases get read here.
        add_row(mk_req(OP_LOAD_BIAS, 3'd0, 4'd0, '0, '0, 32'h0000_0000, '0));
        add_row(mk_req(OP_LOAD_BIAS, 3'd1, 4'd0, '0, '0, 32'h0000_0000, '0));
        add_row(mk_req(OP_LOAD_ENTRY, 3'd0, 4'd0, 32'h0000_0000, 32'h0000_0000, '0, '0));
        add_row(mk_req(OP_LOAD_ENTRY, 3'd1, 4'd0, 32'h0000_0000, 32'h0000_0000, '0, '0));
        // all-zero model: exact tie, class 0 wins
        add_row(mk_req(OP_FEATURE, 3'd0, 4'd0, '0, '0, '0, 32'h0000_0000),
                1'b1, 3'd0, 48'h0000_0000_0000);
        // unused opcode with every field at all ones: no effect
        add_row(mk_req(OP_NONE, 3'd7, 4'd15, '1, '1, '1, '1));
        add_row(mk_req(OP_LOAD_ENTRY, 3'd1, 4'd0, 32'h8000_0000, 32'hFFFF_FFFF, '0, '0));
        // widest distance, largest weight: class 1 penalty saturates
        add_row(mk_req(OP_FEATURE, 3'd0, 4'd0, '0, '0, '0, 32'h7FFF_FFFF),
                1'b1, 3'd0, 48'h0000_0000_0000);
        add_row(mk_req(OP_LOAD_BIAS, 3'd0, 4'd0, '0, '0, 32'h8000_0000, '0));
        add_row(mk_req(OP_FEATURE, 3'd0, 4'd0, '0, '0, '0, 32'h7FFF_FFFF),
                1'b1, 3'd0, 48'hFFFF_8000_0000);
        add_row(mk_req(OP_LOAD_BIAS, 3'd1, 4'd0, '0, '0, 32'h7FFF_FFFF, '0));
        // x equals the most negative mean: zero penalty, largest bias wins
        add_row(mk_req(OP_FEATURE, 3'd0, 4'd0, '0, '0, '0, 32'h8000_0000),
                1'b1, 3'd1, 48'h0000_7FFF_FFFF);
        add_row(mk_req(OP_LOAD_ENTRY, 3'd0, 4'd0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, '0, '0));
        add_row(mk_req(OP_LOAD_BIAS, 3'd1, 4'd0, '0, '0, 32'h8000_0000, '0));
        // both scores pinned at the bottom of the range, tie to class 0
        add_row(mk_req(OP_FEATURE, 3'd0, 4'd0, '0, '0, '0, 32'h0000_0000),
                1'b1, 3'd0, 48'h8000_0000_0000);
        // mean 1.0, weight 1.0: plain fractional arithmetic
        add_row(mk_req(OP_LOAD_ENTRY, 3'd0, 4'd0, 32'h0001_0000, 32'h0001_0000, '0, '0));
        add_row(mk_req(OP_LOAD_BIAS, 3'd0, 4'd0, '0, '0, 32'h0000_0000, '0));
        add_row(mk_req(OP_FEATURE, 3'd0, 4'd0, '0, '0, '0, 32'h0003_0000));
        add_row(mk_req(OP_FEATURE, 3'd7, 4'd15, '0, '0, '0, 32'hFFFF_0000));
        // highest class and attribute addresses
        add_row(mk_req(OP_LOAD_ENTRY, 3'd7, 4'd15, 32'h1234_5678, 32'h0000_ABCD, '0, '0));
        add_row(mk_req(OP_LOAD_BIAS, 3'd7, 4'd0, '0, '0, 32'hFEDC_BA98, '0));
        foreach (dir_rows[i]) send_req(dir_rows[i].rq, dir_rows[i].typed,
                                       dir_rows[i].cls, dir_rows[i].score);

        // fill the whole model so no later feature reads a blank entry
        for (int c = 0; c < MAX_CLASSES; c++) begin
            send_req(mk_req(OP_LOAD_BIAS, CLS_W'(c), ATTR_W'($urandom), $urandom, $urandom,
                            rand_spread(32'h0100_0000), $urandom));
            for (int a = 0; a < MAX_ATTRS; a++) begin
                send_req(mk_req(OP_LOAD_ENTRY, CLS_W'(c), ATTR_W'(a),
                                rand_spread(32'h0010_0000),
                                rand_spread(32'h0001_0000) + 32'h0001_0000,
                                $urandom, $urandom));
            end
        end

        // random phases; counts change only with nothing in flight, though a
        // sample may still be open across the change
        foreach (ph_nc[p]) begin
            settle();
            cfg_write(REG_NUM_CLASSES, APB_DW'(ph_nc[p]));
            cfg_write(REG_NUM_ATTRS, APB_DW'(ph_na[p]));
            run_random(PHASE_ITEMS);
        end

        s_axis_tvalid <= 1'b0;
        while (verdicts_due.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("gaussian_naive_bayes_classifier_unit_tb: done, clean");
        end else begin
            $display("gaussian_naive_bayes_classifier_unit_tb: done, errors");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Master-side receiver: segments of always-ready, coin-flip and
    // periodic ready, plus one long hold-off once results are flowing
    // ------------------------------------------------------------------
    initial begin
        int  seg;
        int  mode;
        int  k;
        bit  held;
        held = 1'b0;
        m_axis_tready <= 1'b0;
        forever begin
            mode = $urandom_range(0, 2);
            seg  = $urandom_range(20, 200);
            k    = $urandom_range(2, 5);
            for (int i = 0; i < seg; i++) begin
                @(posedge i_clk);
                if (!held && results_seen >= 20) begin
                    // sender keeps offering; output register fills, input backs up
                    held = 1'b1;
                    m_axis_tready <= 1'b0;
                    repeat (HOLD_OFF) @(posedge i_clk);
                end
                case (mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= 1'($urandom_range(0, 1));
                    default: m_axis_tready <= (i % k == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Result check against the oldest expected request
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_verdict want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (verdicts_due.size() == 0) begin
                $error("unexpected result: class %0d score %0h",
                       m_axis_tdata[CLS_W-1:0], m_axis_tdata[CLS_W +: SCORE_W]);
                mismatch_count++;
            end else begin
                want = verdicts_due.pop_front();
                if (m_axis_tdata[CLS_W-1:0] !== want.cls) begin
                    $error("predicted_class: expected %0d, got %0d",
                           want.cls, m_axis_tdata[CLS_W-1:0]);
                    mismatch_count++;
                end
                if (m_axis_tdata[CLS_W +: SCORE_W] !== want.score) begin
                    $error("best_score: expected %0h, got %0h",
                           want.score, m_axis_tdata[CLS_W +: SCORE_W]);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog: any handshake on either stream or the config port is progress
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable && pready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("gaussian_naive_bayes_classifier_unit_tb: done, errors");
            $finish;
        end
    end

endmodule
